// ===== src/calendar_date_add_days_assert.svh =====
// assertion macros for the calendar date adder
`ifndef CALENDAR_DATE_ADD_DAYS_ASSERT_SVH
`define CALENDAR_DATE_ADD_DAYS_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define CDAD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cdad assertion failed");
// next-cycle implication
`define CDAD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cdad assertion failed");
`else
`define CDAD_ASSERT_NOW(label, clk, rst, ante, cons)
`define CDAD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/cdad_pkg.sv =====
// shared types and constants for the calendar date adder
package cdad_pkg;

   localparam int YEAR_BITS_DEF  = 16;
   localparam int COUNT_BITS_DEF = 16;

   // year residue modulo the 400-year gregorian cycle
   localparam int RES_W = 9;
   localparam logic [RES_W-1:0] YEAR_CYCLE_M1 = 9'd399;

   // month numbers
   localparam logic [3:0] MONTH_JAN = 4'd1;
   localparam logic [3:0] MONTH_FEB = 4'd2;
   localparam logic [3:0] MONTH_MAR = 4'd3;
   localparam logic [3:0] MONTH_APR = 4'd4;
   localparam logic [3:0] MONTH_JUN = 4'd6;
   localparam logic [3:0] MONTH_SEP = 4'd9;
   localparam logic [3:0] MONTH_NOV = 4'd11;
   localparam logic [3:0] MONTH_DEC = 4'd12;

   typedef struct packed {
      logic [4:0]  day_in;
      logic [3:0]  month_in;
      logic [15:0] year_in;
      logic [15:0] days_to_add;
   } req_type;

   typedef struct packed {
      logic [4:0]  day_out;
      logic [3:0]  month_out;
      logic [15:0] year_out;
      logic [2:0]  weekday;
      logic        date_valid;
   } rsp_type;

   // status of the modulo-400 unit
   typedef struct packed {
      logic             done;
      logic [RES_W-1:0] rem;
   } mod_stat_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_CHECK,
      ST_STEP,
      ST_FINISH
   } state_type;

endpackage

// ===== src/cdad_mod400.sv =====
// remainder of a year value modulo 400 by reciprocal multiplication
module cdad_mod400 #(
   parameter int YEAR_BITS = cdad_pkg::YEAR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [YEAR_BITS-1:0]   value,
   output cdad_pkg::mod_stat_type stat
);

   // 400 is 16 * 25: the low four bits pass through, the upper bits are reduced modulo 25
   localparam int HI_W    = YEAR_BITS - 4;
   localparam int SHIFT   = HI_W + 5;
   localparam int MAGIC_W = HI_W + 1;
   localparam int PROD_W  = HI_W + MAGIC_W;
   localparam int QUOT_W  = PROD_W - SHIFT;
   localparam longint unsigned MAGIC = ((64'd1 << SHIFT) + 64'd24) / 64'd25;

   logic [HI_W-1:0]            hi_ff, hi_in;
   logic [3:0]                 lo_ff, lo_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [cdad_pkg::RES_W-1:0] rem_ff, rem_in;
   logic                       load_ff, mul_ff, done_ff;
   logic [QUOT_W-1:0]          quot;
   logic [HI_W-1:0]            rem25;

   // operand capture
   assign hi_in = start ? value[YEAR_BITS-1:4] : hi_ff;
   assign lo_in = start ? value[3:0] : lo_ff;

   // quotient by 25 from the scaled reciprocal
   assign prod_in = PROD_W'(hi_ff) * PROD_W'(MAGIC_W'(MAGIC));
   assign quot    = prod_ff[PROD_W-1:SHIFT];

   // remainder by 25, then the low bits appended
   assign rem25  = hi_ff - HI_W'(quot) * HI_W'(25);
   assign rem_in = {rem25[4:0], lo_ff};

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff <= 1'b0;
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         load_ff <= start;
         mul_ff  <= load_ff;
         done_ff <= mul_ff;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign stat.done = done_ff;
   assign stat.rem  = rem_ff;

endmodule

// ===== src/calendar_date_add_days.sv =====
// Gregorian date adder with Zeller weekday. One item is handled at a time. After the input
// transfer the year is reduced modulo 400 in a reciprocal-multiply unit, a check state
// validates the date and forms the weekday, the stepper then advances one month per
// cycle until the remaining count fits in the current month, and a finish state moves the
// result into the output register. The input stalls until the result appears there. An
// invalid date skips the stepping. The result sits in an output register, so the next
// item is taken while it waits; a result still held there delays the next one in its
// final cycle.
`include "calendar_date_add_days_assert.svh"

module calendar_date_add_days #(
   parameter int YEAR_BITS  = cdad_pkg::YEAR_BITS_DEF,
   parameter int COUNT_BITS = cdad_pkg::COUNT_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cdad_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cdad_pkg::rsp_type rsp_data
);

   // leap year from the residue modulo 400
   function automatic logic leap_res(input logic [cdad_pkg::RES_W-1:0] r);
      return (r[1:0] == 2'b00) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      case (m)
         cdad_pkg::MONTH_FEB: d = leap ? 5'd29 : 5'd28;
         cdad_pkg::MONTH_APR: d = 5'd30;
         cdad_pkg::MONTH_JUN: d = 5'd30;
         cdad_pkg::MONTH_SEP: d = 5'd30;
         cdad_pkg::MONTH_NOV: d = 5'd30;
         default:             d = 5'd31;
      endcase
      return d;
   endfunction

   // 13 * (m + 1) / 5 with january and february as months 13 and 14
   function automatic logic [5:0] zeller_term(input logic [3:0] m);
      logic [5:0] t;
      case (m)
         4'd1:    t = 6'd36;
         4'd2:    t = 6'd39;
         4'd3:    t = 6'd10;
         4'd4:    t = 6'd13;
         4'd5:    t = 6'd15;
         4'd6:    t = 6'd18;
         4'd7:    t = 6'd20;
         4'd8:    t = 6'd23;
         4'd9:    t = 6'd26;
         4'd10:   t = 6'd28;
         4'd11:   t = 6'd31;
         4'd12:   t = 6'd33;
         default: t = 6'd0;
      endcase
      return t;
   endfunction

   // modulo 7 by folding octal digits, since 8 is 1 modulo 7
   function automatic logic [2:0] mod7(input logic [9:0] x);
      logic [4:0] s;
      logic [3:0] f;
      s = 5'(x[2:0]) + 5'(x[5:3]) + 5'(x[8:6]) + 5'(x[9]);
      f = 4'(s[2:0]) + 4'(s[4:3]);
      return (f >= 4'd7) ? 3'(f - 4'd7) : 3'(f);
   endfunction

   cdad_pkg::state_type        state_ff, state_in;
   logic [4:0]                 day_ff, day_in;
   logic [3:0]                 month_ff, month_in;
   logic [YEAR_BITS-1:0]       year_ff, year_in;
   logic [COUNT_BITS-1:0]      left_ff, left_in;
   logic [cdad_pkg::RES_W-1:0] res_ff, res_in;
   logic                       valid_ff, valid_in;
   logic [2:0]                 wday_ff, wday_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   cdad_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                       req_accept;
   logic                       rsp_free;
   logic                       mod_start;
   logic [YEAR_BITS-1:0]       mod_value;
   cdad_pkg::mod_stat_type     mod_stat;
   logic [cdad_pkg::RES_W-1:0] res_next;
   logic [cdad_pkg::RES_W-1:0] yres;
   logic [4:0]                 dim_chk;
   logic                       valid_chk;
   logic [1:0]                 q100;
   logic [9:0]                 wsum;
   logic [4:0]                 dim;
   logic [4:0]                 to_end;
   logic [YEAR_BITS-1:0]       year_next;

   assign req_stall  = (state_ff != cdad_pkg::ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // zeller year: one less for january and february
   assign mod_value = YEAR_BITS'(req_data.year_in)
                    - ((req_data.month_in < cdad_pkg::MONTH_MAR) ? YEAR_BITS'(1)
                                                                 : YEAR_BITS'(0));

   cdad_mod400 #(
      .YEAR_BITS (YEAR_BITS)
   ) u_mod400 (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .value (mod_value),
      .stat  (mod_stat)
   );

   // residue of the next year in the 400-year cycle
   assign res_next = (res_ff == cdad_pkg::YEAR_CYCLE_M1) ? '0
                                                       : res_ff + cdad_pkg::RES_W'(1);

   // validation and weekday, from the zeller year residue
   assign yres      = (month_ff < cdad_pkg::MONTH_MAR) ? res_next : res_ff;
   assign dim_chk   = month_days(month_ff, leap_res(yres));
   assign valid_chk = (year_ff != '0) && (month_ff >= cdad_pkg::MONTH_JAN)
                   && (month_ff <= cdad_pkg::MONTH_DEC) && (day_ff != '0)
                   && (day_ff <= dim_chk);
   assign q100 = (res_ff >= 9'd300) ? 2'd3 :
                 (res_ff >= 9'd200) ? 2'd2 :
                 (res_ff >= 9'd100) ? 2'd1 : 2'd0;
   // the 400-year quotient drops out since 497 is a multiple of 7
   assign wsum = 10'(res_ff) + 10'(res_ff[cdad_pkg::RES_W-1:2]) + 10'(day_ff)
               + 10'(zeller_term(month_ff)) - 10'(q100);

   // month stepper
   assign dim       = month_days(month_ff, leap_res(res_ff));
   assign to_end    = dim - day_ff;
   assign year_next = year_ff + YEAR_BITS'(1);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      left_in      = left_ff;
      res_in       = res_ff;
      valid_in     = valid_ff;
      wday_in      = wday_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mod_start    = 1'b0;
      case (state_ff)
         cdad_pkg::ST_IDLE: begin
            if (req_accept) begin
               day_in    = req_data.day_in;
               month_in  = req_data.month_in;
               year_in   = YEAR_BITS'(req_data.year_in);
               left_in   = COUNT_BITS'(req_data.days_to_add);
               mod_start = 1'b1;
               state_in  = cdad_pkg::ST_DIV;
            end
         end
         cdad_pkg::ST_DIV: begin
            if (mod_stat.done) begin
               res_in   = mod_stat.rem;
               state_in = cdad_pkg::ST_CHECK;
            end
         end
         cdad_pkg::ST_CHECK: begin
            valid_in = valid_chk;
            wday_in  = valid_chk ? mod7(wsum) : 3'd0;
            res_in   = yres;
            state_in = valid_chk ? cdad_pkg::ST_STEP : cdad_pkg::ST_FINISH;
         end
         cdad_pkg::ST_STEP: begin
            if (left_ff <= COUNT_BITS'(to_end)) begin
               day_in   = day_ff + left_ff[4:0];
               left_in  = '0;
               state_in = cdad_pkg::ST_FINISH;
            end else begin
               left_in = left_ff - COUNT_BITS'(to_end) - COUNT_BITS'(1);
               day_in  = 5'd1;
               if (month_ff == cdad_pkg::MONTH_DEC) begin
                  month_in = cdad_pkg::MONTH_JAN;
                  year_in  = year_next;
                  res_in   = (year_next == '0) ? '0 : res_next;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end
         end
         cdad_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_data_in.day_out    = day_ff;
               rsp_data_in.month_out  = month_ff;
               rsp_data_in.year_out   = 16'(year_ff);
               rsp_data_in.weekday    = wday_ff;
               rsp_data_in.date_valid = valid_ff;
               rsp_valid_in           = 1'b1;
               state_in               = cdad_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdad_pkg::ST_IDLE;
         end
      endcase
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdad_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      day_ff      <= day_in;
      month_ff    <= month_in;
      year_ff     <= year_in;
      left_ff     <= left_in;
      res_ff      <= res_in;
      valid_ff    <= valid_in;
      wday_ff     <= wday_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // checks
   `CDAD_ASSERT_NEXT(a_accept_starts_div, clock, reset, req_accept, state_ff == cdad_pkg::ST_DIV)
   `CDAD_ASSERT_NOW(a_done_in_div, clock, reset, mod_stat.done, state_ff == cdad_pkg::ST_DIV)
   `CDAD_ASSERT_NOW(a_step_date_ok, clock, reset, state_ff == cdad_pkg::ST_STEP,
      (day_ff != 5'd0) && (month_ff >= cdad_pkg::MONTH_JAN) && (month_ff <= cdad_pkg::MONTH_DEC))
   `CDAD_ASSERT_NOW(a_invalid_no_wday, clock, reset, rsp_valid_ff && !rsp_data_ff.date_valid,
      rsp_data_ff.weekday == 3'd0)

endmodule
